// ===== sv/bdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and codes shared by the bounded deque and its cell chains.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int VALUE_W = 32;
	localparam int ITEM_COUNT_W = 5;

	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_CLEAR      = 3'd4
	} bdq_action_t;

	typedef enum logic [1:0] {
		FAULT_OK    = 2'd0,
		FAULT_EMPTY = 2'd1,
		FAULT_FULL  = 2'd2
	} bdq_fault_t;

	typedef logic signed [VALUE_W-1:0] bdq_value_t;

	typedef struct packed {
		logic [2:0] action;
		bdq_value_t push_value;
	} bdq_req_t;

	typedef struct packed {
		bdq_value_t              front_value;
		bdq_value_t              back_value;
		logic [ITEM_COUNT_W-1:0] item_count;
		logic [1:0]              fault;
	} bdq_rsp_t;

	// Per-transfer command to one chain of cells
	typedef struct packed {
		logic shift_right;
		logic shift_left;
		logic write_tail;
	} bdq_ctl_t;

endpackage
`default_nettype wire

// ===== sv/bounded_deque.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque
// Bounded double-ended queue of signed 32-bit values in two rows of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries an action and a push value;
//   rsp channel (rsp_valid/rsp_stall/rsp) returns one result per request:
//   front and back values after the operation, entry count and fault code.
//   A request is applied on the cycle it transfers and its result sits in the
//   output register from the next cycle; one request per cycle is sustained
//   while no stalled result is pending. The rate is set by the cell rows and
//   the count register, which both update on each transfer.
//   Storage is two chains of DEPTH cells: one ordered front-to-back, one
//   back-to-front, so both ends are always read from cell 0 of a chain.
//   Pop on empty reports fault 1, push on full reports fault 2; neither
//   changes the contents. Front and back read as zero when empty.
//   Reset empties the queue and drops any pending result; cell contents are
//   not cleared. While rsp_stall holds a pending result, req_stall is raised
//   and the result is held unchanged.
// ----------------------------------------------------------------------------
module bounded_deque #(
	parameter int DEPTH = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  wire bdq_pkg::bdq_req_t  req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output bdq_pkg::bdq_rsp_t       rsp
);
	import bdq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic          rsp_valid_q;
	bdq_rsp_t      rsp_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic          xfer;
	logic          full;
	logic          empty;
	bdq_ctl_t      fwd_ctl;
	bdq_ctl_t      rev_ctl;
	bdq_value_t    front_next;
	bdq_value_t    back_next;
	logic [1:0]    fault;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign xfer      = req_valid && !req_stall;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);

	always_comb begin
		fwd_ctl    = '0;
		rev_ctl    = '0;
		count_next = count_q;
		fault      = FAULT_OK;
		case (req.action)
			ACT_PUSH_FRONT: begin
				if (full) begin
					fault = FAULT_FULL;
				end else begin
					fwd_ctl.shift_right = xfer;
					rev_ctl.write_tail  = xfer;
					count_next          = count_q + CW'(1);
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					fault = FAULT_FULL;
				end else begin
					fwd_ctl.write_tail  = xfer;
					rev_ctl.shift_right = xfer;
					count_next          = count_q + CW'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					fault = FAULT_EMPTY;
				end else begin
					fwd_ctl.shift_left = xfer;
					count_next         = count_q - CW'(1);
				end
			end
			ACT_POP_BACK: begin
				if (empty) begin
					fault = FAULT_EMPTY;
				end else begin
					rev_ctl.shift_left = xfer;
					count_next         = count_q - CW'(1);
				end
			end
			ACT_CLEAR: begin
				count_next = '0;
			end
			default: begin
			end
		endcase
	end

	bdq_chain #(.DEPTH(DEPTH), .CW(CW)) u_fwd (
		.clk        (clk),
		.ctl        (fwd_ctl),
		.count_q    (count_q),
		.push_value (req.push_value),
		.head_next  (front_next)
	);

	bdq_chain #(.DEPTH(DEPTH), .CW(CW)) u_rev (
		.clk        (clk),
		.ctl        (rev_ctl),
		.count_q    (count_q),
		.push_value (req.push_value),
		.head_next  (back_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture the post-operation view; gate the ends when nothing is stored
	always_ff @(posedge clk) begin
		if (xfer) begin
			rsp_q.front_value <= (count_next == '0) ? '0 : front_next;
			rsp_q.back_value  <= (count_next == '0) ? '0 : back_next;
			rsp_q.item_count  <= ITEM_COUNT_W'(count_next);
			rsp_q.fault       <= fault;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ===== sv/bdq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell: takes a neighbour's value on a shift, or the pushed value
// when it is the tail slot being written.
// ----------------------------------------------------------------------------
module bdq_cell (
	input  wire                 clk,
	input  wire bdq_pkg::bdq_ctl_t  ctl,
	input  wire                 write_here,
	input  wire bdq_pkg::bdq_value_t left_in,
	input  wire bdq_pkg::bdq_value_t right_in,
	input  wire bdq_pkg::bdq_value_t push_value,
	output bdq_pkg::bdq_value_t      data_next,
	output bdq_pkg::bdq_value_t      data_q
);
	import bdq_pkg::*;

	always_comb begin
		data_next = data_q;
		if (ctl.shift_right) begin
			data_next = left_in;
		end else if (ctl.shift_left) begin
			data_next = right_in;
		end else if (write_here) begin
			data_next = push_value;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

endmodule
`default_nettype wire

// ===== sv/bdq_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_chain
// Row of cells holding the queue in order from one end; cell 0 is the head.
// Shift right inserts at the head, shift left drops the head, a tail write
// lands in the cell whose index equals the entry count.
// ----------------------------------------------------------------------------
module bdq_chain #(
	parameter int DEPTH = 16,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire                 clk,
	input  wire bdq_pkg::bdq_ctl_t  ctl,
	input  wire [CW-1:0]        count_q,
	input  wire bdq_pkg::bdq_value_t push_value,
	output bdq_pkg::bdq_value_t      head_next
);
	import bdq_pkg::*;

	bdq_value_t data_q    [DEPTH];
	bdq_value_t data_next [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bdq_value_t left_in;
		bdq_value_t right_in;
		logic       write_here;

		if (i == 0) begin : g_head
			assign left_in = push_value;
		end else begin : g_body
			assign left_in = data_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_inner
			assign right_in = data_q[i+1];
		end

		assign write_here = ctl.write_tail && (count_q == CW'(i));

		bdq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.write_here (write_here),
			.left_in    (left_in),
			.right_in   (right_in),
			.push_value (push_value),
			.data_next  (data_next[i]),
			.data_q     (data_q[i])
		);
	end

	assign head_next = data_next[0];

endmodule
`default_nettype wire

// ===== tb/bounded_deque_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_tb
// Self-checking bench for the bounded deque. A short table of directed
// operations (empty pops, clear, a spare code, value extremes, fill to full)
// is followed by random operation runs biased to fill, drain or mix.
// Results are checked field by field against table expectations where given,
// else against a behavioural shadow, while both channels idle at random.
// ----------------------------------------------------------------------------
module bounded_deque_tb;
	import bdq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int RANDOM_ITEMS = 450;
	localparam int IDLE_LIMIT = 200;
	localparam int REPORT_LIMIT = 10;
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST = 3'd7;
	localparam bdq_value_t VALUE_MAX = 32'sh7FFF_FFFF;
	localparam bdq_value_t VALUE_MIN = 32'sh8000_0000;

	typedef struct {
		logic [2:0] act;
		bdq_value_t val;
		bit         typed;
		bdq_rsp_t   want;
	} stim_row_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	bdq_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	bdq_rsp_t rsp;

	// Shadow of the deque contents
	bdq_value_t shadow_store [QUEUE_DEPTH];
	logic [3:0] shadow_head = '0;
	logic [4:0] shadow_fill = '0;

	bdq_rsp_t  awaited_views [$];
	stim_row_t stim_rows [$];
	int        mismatch_count = 0;
	int        idle_cycles = 0;
	bit        burst = 1'b0;

	bounded_deque #(
		.DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Apply one operation to the shadow and return the view that follows it
	function automatic bdq_rsp_t apply_action(input logic [2:0] act, input bdq_value_t val);
		bdq_rsp_t   view;
		logic [3:0] tail;
		bdq_fault_t fault;
		fault = FAULT_OK;
		case (act)
			ACT_PUSH_FRONT: begin
				if (shadow_fill == QUEUE_DEPTH) begin
					fault = FAULT_FULL;
				end else begin
					shadow_head = shadow_head - 4'd1;
					shadow_store[shadow_head] = val;
					shadow_fill = shadow_fill + 5'd1;
				end
			end
			ACT_PUSH_BACK: begin
				if (shadow_fill == QUEUE_DEPTH) begin
					fault = FAULT_FULL;
				end else begin
					tail = shadow_head + shadow_fill[3:0];
					shadow_store[tail] = val;
					shadow_fill = shadow_fill + 5'd1;
				end
			end
			ACT_POP_FRONT: begin
				if (shadow_fill == 0) begin
					fault = FAULT_EMPTY;
				end else begin
					shadow_head = shadow_head + 4'd1;
					shadow_fill = shadow_fill - 5'd1;
				end
			end
			ACT_POP_BACK: begin
				if (shadow_fill == 0)
					fault = FAULT_EMPTY;
				else
					shadow_fill = shadow_fill - 5'd1;
			end
			ACT_CLEAR: begin
				shadow_fill = '0;
				shadow_head = '0;
			end
			default: ;
		endcase
		view = '0;
		if (shadow_fill != 0) begin
			tail = shadow_head + shadow_fill[3:0] - 4'd1;
			view.front_value = shadow_store[shadow_head];
			view.back_value = shadow_store[tail];
		end
		view.item_count = shadow_fill;
		view.fault = fault;
		return view;
	endfunction

	task automatic add_row(input logic [2:0] act, input bdq_value_t val, input bit typed,
			input bdq_value_t front, input bdq_value_t back, input int count,
			input bdq_fault_t fault);
		stim_row_t row;
		row.act = act;
		row.val = val;
		row.typed = typed;
		row.want.front_value = front;
		row.want.back_value = back;
		row.want.item_count = count[4:0];
		row.want.fault = fault;
		stim_rows.push_back(row);
	endtask

	task automatic note_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: %s differs: expected %h, got %h", $realtime, field, want, got);
		end
	endtask

	task automatic check_result(input bdq_rsp_t got);
		bdq_rsp_t want;
		if (awaited_views.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: result %h arrived with none outstanding", $realtime, got);
		end else begin
			want = awaited_views.pop_front();
			note_field("front_value", want.front_value, got.front_value);
			note_field("back_value", want.back_value, got.back_value);
			note_field("item_count", want.item_count, got.item_count);
			note_field("fault", want.fault, got.fault);
		end
	endtask

	// Offer one request and hold it until the transfer
	task automatic send_item(input bdq_req_t item, input bit typed, input bdq_rsp_t want);
		int       gap;
		bdq_rsp_t view;
		gap = burst ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		view = apply_action(item.action, item.push_value);
		awaited_views.push_back(typed ? want : view);
	endtask

	initial begin : request_side
		bdq_req_t item;
		int       mode;
		int       mode_left;
		int       pick;
		int       push_share;

		add_row(ACT_POP_FRONT, 32'sd0, 1'b1, 32'sd0, 32'sd0, 0, FAULT_EMPTY);
		add_row(ACT_POP_BACK, 32'sd0, 1'b1, 32'sd0, 32'sd0, 0, FAULT_EMPTY);
		add_row(ACT_CLEAR, 32'sd0, 1'b1, 32'sd0, 32'sd0, 0, FAULT_OK);
		add_row(ACT_SPARE_FIRST, 32'sh5A5A_5A5A, 1'b1, 32'sd0, 32'sd0, 0, FAULT_OK);
		add_row(ACT_PUSH_BACK, VALUE_MAX, 1'b1, VALUE_MAX, VALUE_MAX, 1, FAULT_OK);
		add_row(ACT_PUSH_FRONT, VALUE_MIN, 1'b1, VALUE_MIN, VALUE_MAX, 2, FAULT_OK);
		add_row(ACT_POP_BACK, 32'sd0, 1'b1, VALUE_MIN, VALUE_MIN, 1, FAULT_OK);
		add_row(ACT_POP_FRONT, 32'sd0, 1'b1, 32'sd0, 32'sd0, 0, FAULT_OK);
		// fill to capacity from both ends, then overflow
		for (int i = 0; i < QUEUE_DEPTH; i++)
			add_row(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
				(i[0] ? 32'shAAAA_AAAA : 32'sh5555_5555) ^ i, 1'b0,
				32'sd0, 32'sd0, 0, FAULT_OK);
		add_row(ACT_PUSH_BACK, 32'sh1234_5678, 1'b0, 32'sd0, 32'sd0, 0, FAULT_OK);
		add_row(ACT_CLEAR, 32'sd0, 1'b1, 32'sd0, 32'sd0, 0, FAULT_OK);

		@(posedge arst_n);
		@(posedge clk);
		foreach (stim_rows[i]) begin
			item.action = stim_rows[i].act;
			item.push_value = stim_rows[i].val;
			send_item(item, stim_rows[i].typed, stim_rows[i].want);
		end

		// runs biased towards filling, draining or a mix
		mode = 0;
		mode_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 40);
				burst = ($urandom_range(0, 3) == 0);
			end
			mode_left--;
			push_share = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
			pick = $urandom_range(0, 99);
			if (pick < 3)
				item.action = ACT_CLEAR;
			else if (pick < 5)
				item.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
			else if ($urandom_range(0, 99) < push_share)
				item.action = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
			else
				item.action = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
			case ($urandom_range(0, 9))
				0: item.push_value = VALUE_MAX;
				1: item.push_value = VALUE_MIN;
				2: item.push_value = 32'sd0;
				3: item.push_value = -32'sd1;
				default: item.push_value = $urandom;
			endcase
			send_item(item, 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (awaited_views.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : result_side
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				check_result(rsp);
				hold = burst ? 0 : $urandom_range(0, 3);
			end
			rsp_stall <= (hold != 0);
			if (hold != 0)
				hold--;
		end
	end

	// End the run if neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
sv/bdq_pkg.sv
sv/bdq_cell.sv
sv/bdq_chain.sv
sv/bounded_deque.sv
tb/bounded_deque_tb.sv
